// ===== design/fst_pkg.sv =====
// Shared constants, command and status types for the FCFS schedule block.
`timescale 1ns / 1ps

package fst_pkg;

    // Store depth and the index and count widths that follow from it.
    localparam int MAX_PROCESSES = 64;
    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    // Field widths of the input and result items.
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int TIME_W = 23;
    localparam int PNUM_W = 6;

    // Controller states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_RFETCH,
        S_RLATCH,
        S_RSCAN,
        S_RWRITE,
        S_SORD,
        S_SSTORE,
        S_SCALC,
        S_SDONE,
        S_SWRITE,
        S_EFETCH,
        S_ELOAD
    } fst_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_we;
        logic [IDX_W-1:0] load_addr;
        logic             store_re;
        logic             store_sel_order;
        logic [IDX_W-1:0] store_raddr;
        logic             ai_latch;
        logic             rank_clr;
        logic             rank_acc;
        logic [IDX_W-1:0] cmp_idx;
        logic [IDX_W-1:0] cur_idx;
        logic             ord_we;
        logic             ord_re;
        logic [IDX_W-1:0] ord_addr;
        logic             p_latch;
        logic             time_clr;
        logic             start_calc;
        logic             done_calc;
        logic             res_we;
        logic             res_re;
        logic [IDX_W-1:0] res_addr;
        logic             out_load;
        logic             out_last;
    } fst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } fst_status_t;

endpackage

// ===== design/fst_ctrl.sv =====
// Controller state machine that sequences loading, ranking, scheduling and emission.
`timescale 1ns / 1ps

module fst_ctrl
    import fst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        last_process,
    input  fst_status_t status,
    output fst_cmd_t    cmd
);

    fst_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             idx_is_last;

    // The shared index has reached the final process of the set.
    assign idx_is_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            j_reg     <= j_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        cmd        = '0;
        item_ready = 1'b0;
        cmd.load_addr = cnt_reg[IDX_W-1:0];
        cmd.cur_idx   = idx_reg;
        cmd.ord_addr  = idx_reg;
        cmd.res_addr  = idx_reg;
        case (state_reg)
            S_LOAD:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_we = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    if (last_process || (cnt_reg == CNT_W'(MAX_PROCESSES - 1)))
                    begin
                        idx_next   = '0;
                        state_next = S_RFETCH;
                    end
                end
            end
            S_RFETCH:
            begin
                cmd.store_re    = 1'b1;
                cmd.store_raddr = idx_reg;
                state_next      = S_RLATCH;
            end
            S_RLATCH:
            begin
                // Hold the arrival of process i and start the scan at entry 0.
                cmd.ai_latch    = 1'b1;
                cmd.rank_clr    = 1'b1;
                cmd.store_re    = 1'b1;
                cmd.store_raddr = '0;
                j_next          = CNT_W'(1);
                state_next      = S_RSCAN;
            end
            S_RSCAN:
            begin
                // Compare the entry read last cycle and read the next one.
                cmd.rank_acc = 1'b1;
                cmd.cmp_idx  = IDX_W'(j_reg - CNT_W'(1));
                if (j_reg == cnt_reg)
                begin
                    state_next = S_RWRITE;
                end
                else
                begin
                    cmd.store_re    = 1'b1;
                    cmd.store_raddr = j_reg[IDX_W-1:0];
                    j_next          = j_reg + CNT_W'(1);
                end
            end
            S_RWRITE:
            begin
                cmd.ord_we = 1'b1;
                if (idx_is_last)
                begin
                    cmd.time_clr = 1'b1;
                    idx_next     = '0;
                    state_next   = S_SORD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_RFETCH;
                end
            end
            S_SORD:
            begin
                cmd.ord_re = 1'b1;
                state_next = S_SSTORE;
            end
            S_SSTORE:
            begin
                cmd.store_re        = 1'b1;
                cmd.store_sel_order = 1'b1;
                cmd.p_latch         = 1'b1;
                state_next          = S_SCALC;
            end
            S_SCALC:
            begin
                cmd.start_calc = 1'b1;
                state_next     = S_SDONE;
            end
            S_SDONE:
            begin
                cmd.done_calc = 1'b1;
                state_next    = S_SWRITE;
            end
            S_SWRITE:
            begin
                cmd.res_we = 1'b1;
                if (idx_is_last)
                begin
                    idx_next   = '0;
                    state_next = S_EFETCH;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SORD;
                end
            end
            S_EFETCH:
            begin
                if (status.out_free)
                begin
                    cmd.res_re = 1'b1;
                    state_next = S_ELOAD;
                end
            end
            S_ELOAD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_last = idx_is_last;
                if (idx_is_last)
                begin
                    cnt_next   = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_EFETCH;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ===== design/fst_dp.sv =====
// Datapath: process stores, rank compare, schedule arithmetic and result register.
`timescale 1ns / 1ps

module fst_dp
    import fst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  fst_cmd_t           cmd,
    output fst_status_t        status,
    input  logic [ARR_W-1:0]   arrival_time,
    input  logic [BUR_W-1:0]   burst_time,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [PNUM_W-1:0]  process_number,
    output logic [TIME_W-1:0]  turnaround_time,
    output logic [TIME_W-1:0]  waiting_time,
    output logic               last_result
);

    // Memories.
    logic [ARR_W+BUR_W-1:0]  store_mem [MAX_PROCESSES];
    logic [IDX_W-1:0]        ord_mem   [MAX_PROCESSES];
    logic [2*TIME_W-1:0]     res_mem   [MAX_PROCESSES];

    logic [ARR_W+BUR_W-1:0]  store_rd_reg;
    logic [IDX_W-1:0]        ord_rd_reg;
    logic [2*TIME_W-1:0]     res_rd_reg;
    logic [IDX_W-1:0]        store_raddr;

    logic [ARR_W-1:0]        ai_reg;
    logic [IDX_W-1:0]        rank_reg;
    logic [IDX_W-1:0]        p_reg;
    logic [TIME_W-1:0]       cur_reg;
    logic [TIME_W-1:0]       start_reg;
    logic [TIME_W-1:0]       wait_reg;

    logic                    out_valid_reg;
    logic [PNUM_W-1:0]       pnum_reg;
    logic [TIME_W-1:0]       turn_out_reg;
    logic [TIME_W-1:0]       wait_out_reg;
    logic                    last_reg;

    logic [ARR_W-1:0]        rd_arr;
    logic [BUR_W-1:0]        rd_bur;
    logic [TIME_W-1:0]       rd_arr_ext;
    logic [TIME_W-1:0]       rd_bur_ext;
    logic                    earlier;

    assign rd_arr     = store_rd_reg[ARR_W+BUR_W-1:BUR_W];
    assign rd_bur     = store_rd_reg[BUR_W-1:0];
    assign rd_arr_ext = TIME_W'(rd_arr);
    assign rd_bur_ext = TIME_W'(rd_bur);
    assign store_raddr = cmd.store_sel_order ? ord_rd_reg : cmd.store_raddr;

    // Stable order: entry j runs before entry i on an earlier arrival,
    // or on an equal arrival with a lower process number.
    assign earlier = (rd_arr < ai_reg) || ((rd_arr == ai_reg) && (cmd.cmp_idx < cmd.cur_idx));

    // Process store: written on each input transfer, read with a registered port.
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            store_mem[cmd.load_addr] <= {arrival_time, burst_time};
        end
        if (cmd.store_re)
        begin
            store_rd_reg <= store_mem[store_raddr];
        end
    end

    // Run order: process i is written at its rank.
    always_ff @(posedge clk)
    begin
        if (cmd.ord_we)
        begin
            ord_mem[rank_reg] <= cmd.cur_idx;
        end
        if (cmd.ord_re)
        begin
            ord_rd_reg <= ord_mem[cmd.ord_addr];
        end
    end

    // Result store, indexed by process number.
    always_ff @(posedge clk)
    begin
        if (cmd.res_we)
        begin
            res_mem[p_reg] <= {cur_reg - rd_arr_ext, wait_reg};
        end
        if (cmd.res_re)
        begin
            res_rd_reg <= res_mem[cmd.res_addr];
        end
    end

    // Rank accumulation and schedule arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.ai_latch)
        begin
            ai_reg <= rd_arr;
        end
        if (cmd.rank_clr)
        begin
            rank_reg <= '0;
        end
        else if (cmd.rank_acc && earlier)
        begin
            rank_reg <= rank_reg + IDX_W'(1);
        end
        if (cmd.p_latch)
        begin
            p_reg <= ord_rd_reg;
        end
        if (cmd.start_calc)
        begin
            start_reg <= (cur_reg < rd_arr_ext) ? rd_arr_ext : cur_reg;
        end
        if (cmd.done_calc)
        begin
            wait_reg <= start_reg - rd_arr_ext;
        end
    end

    // Schedule clock: cleared at the start of each schedule pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else if (cmd.time_clr)
        begin
            cur_reg <= '0;
        end
        else if (cmd.done_calc)
        begin
            cur_reg <= start_reg + rd_bur_ext;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pnum_reg     <= PNUM_W'(cmd.res_addr);
            turn_out_reg <= res_rd_reg[2*TIME_W-1:TIME_W];
            wait_out_reg <= res_rd_reg[TIME_W-1:0];
            last_reg     <= cmd.out_last;
        end
    end

    assign status.out_free = !out_valid_reg || result_ready;

    assign result_valid    = out_valid_reg;
    assign process_number  = pnum_reg;
    assign turnaround_time = turn_out_reg;
    assign waiting_time    = wait_out_reg;
    assign last_result     = last_reg;

endmodule

// ===== design/fcfs_schedule_times.sv =====
// Input items are taken back to back while the block is loading. After the item that ends a set,
// the block ranks every process, runs the schedule pass, then emits the results one at a time;
// no new item is taken until the last result is loaded. The single read port of the process
// store sets the rank time.
// Reset clears the controller, counts and schedule clock; the stores are not cleared.
`timescale 1ns / 1ps

module fcfs_schedule_times
    import fst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [ARR_W-1:0]   arrival_time,
    input  logic [BUR_W-1:0]   burst_time,
    input  logic               last_process,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [PNUM_W-1:0]  process_number,
    output logic [TIME_W-1:0]  turnaround_time,
    output logic [TIME_W-1:0]  waiting_time,
    output logic               last_result
);

    fst_cmd_t    cmd;
    fst_status_t status;

    // Sequencer.
    fst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .last_process (last_process),
        .status       (status),
        .cmd          (cmd)
    );

    // Stores and arithmetic.
    fst_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .process_number  (process_number),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .last_result     (last_result)
    );

endmodule

// ===== design/fst_checker.sv =====
// Port-level checker for the FCFS schedule block and its bind.
`timescale 1ns / 1ps

module fst_checker
    import fst_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic [ARR_W-1:0]  arrival_time,
    input logic [BUR_W-1:0]  burst_time,
    input logic              last_process,
    input logic              result_valid,
    input logic              result_ready,
    input logic [PNUM_W-1:0] process_number,
    input logic [TIME_W-1:0] turnaround_time,
    input logic [TIME_W-1:0] waiting_time,
    input logic              last_result
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(process_number)
            && $stable(turnaround_time) && $stable(waiting_time) && $stable(last_result))
    else $error("stalled result changed");

    // Waiting time never exceeds turnaround time.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> waiting_time <= turnaround_time)
    else $error("waiting time above turnaround time");

    // A transfer that ends a set stops intake while the set is worked.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && last_process |=> !item_ready)
    else $error("input taken after end of set");

    // While results of a set remain, no new item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last_result |=> !item_ready)
    else $error("input taken during emission");

endmodule

bind fcfs_schedule_times fst_checker u_fst_checker (.*);

// ===== tb/sv/fcfs_schedule_times_test.sv =====
// Self-checking testbench for the FCFS schedule block, with its own scheduling predictor.
`timescale 1ns / 1ps

module fcfs_schedule_times_test;
    import fst_pkg::*;

    // Limit on the run length; the whole run stays far below this.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 320;
    localparam int DIR_N = 15;

    // Value mixes for the random sets.
    typedef enum int {
        SHAPE_WIDE,
        SHAPE_CROWD,
        SHAPE_SPARSE,
        SHAPE_PEAK
    } set_shape_t;

    // One loaded process, with its result typed in where it is obvious.
    typedef struct packed {
        logic [ARR_W-1:0]  arr;
        logic [BUR_W-1:0]  bur;
        logic              last;
        logic              known;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
    } process_t;

    // One schedule result as the block should deliver it.
    typedef struct packed {
        logic [PNUM_W-1:0] pnum;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
        logic              last;
    } sched_result_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    logic [ARR_W-1:0]   arrival_time;
    logic [BUR_W-1:0]   burst_time;
    logic               last_process;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [PNUM_W-1:0]  process_number;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TIME_W-1:0]  waiting_time;
    logic               last_result;

    process_t      open_set[$];
    sched_result_t awaited_results[$];
    int            errors = 0;
    int            items_sent = 0;
    int            cycle_count = 0;
    bit            calm = 1'b0;

    // Directed processes: extremes, ties, idle gaps, out-of-order arrivals, bit patterns.
    process_t dir_rows [DIR_N] = '{
        '{16'd0,     16'd0,     1'b1, 1'b1, 23'd0,      23'd0},
        '{16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 23'd65535,  23'd0},
        '{16'd10,    16'd3,     1'b0, 1'b1, 23'd3,      23'd0},
        '{16'd10,    16'd4,     1'b1, 1'b1, 23'd7,      23'd3},
        '{16'd0,     16'd5,     1'b0, 1'b1, 23'd5,      23'd0},
        '{16'd100,   16'd2,     1'b1, 1'b1, 23'd2,      23'd0},
        '{16'd50,    16'd10,    1'b0, 1'b1, 23'd10,     23'd0},
        '{16'd0,     16'd20,    1'b1, 1'b1, 23'd20,     23'd0},
        '{16'd0,     16'hFFFF,  1'b0, 1'b1, 23'd65535,  23'd0},
        '{16'd0,     16'hFFFF,  1'b0, 1'b1, 23'd131070, 23'd65535},
        '{16'd0,     16'hFFFF,  1'b1, 1'b1, 23'd196605, 23'd131070},
        '{16'hAAAA,  16'h5555,  1'b0, 1'b0, 23'd0,      23'd0},
        '{16'h5555,  16'hAAAA,  1'b0, 1'b0, 23'd0,      23'd0},
        '{16'hFFFF,  16'h0001,  1'b0, 1'b0, 23'd0,      23'd0},
        '{16'h0001,  16'hFFFF,  1'b1, 1'b0, 23'd0,      23'd0}
    };

    fcfs_schedule_times i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .last_process    (last_process),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .process_number  (process_number),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .last_result     (last_result)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Orders the open set by arrival, runs it and queues one result per process.
    function automatic void schedule_open_set();
        int                run_order[$];
        int                n;
        int                i;
        int                j;
        int                p;
        logic [TIME_W-1:0] clock_now;
        logic [TIME_W-1:0] done_at;
        logic [TIME_W-1:0] tat_of [MAX_PROCESSES];
        logic [TIME_W-1:0] wt_of [MAX_PROCESSES];
        sched_result_t     r;
        n = open_set.size();
        // Stable insertion by arrival time: equal arrivals keep loading order.
        for (i = 0; i < n; i++)
        begin
            j = run_order.size();
            while (j > 0 && open_set[run_order[j - 1]].arr > open_set[i].arr)
                j--;
            run_order.insert(j, i);
        end
        // Non-preemptive run; the clock jumps ahead to the next arrival when idle.
        clock_now = '0;
        for (i = 0; i < n; i++)
        begin
            p = run_order[i];
            if (clock_now < TIME_W'(open_set[p].arr))
                clock_now = TIME_W'(open_set[p].arr);
            done_at = clock_now + TIME_W'(open_set[p].bur);
            tat_of[p] = done_at - TIME_W'(open_set[p].arr);
            wt_of[p] = tat_of[p] - TIME_W'(open_set[p].bur);
            clock_now = done_at;
        end
        // Results leave in loading order.
        for (i = 0; i < n; i++)
        begin
            r.pnum = PNUM_W'(i);
            r.tat = open_set[i].known ? open_set[i].tat : tat_of[i];
            r.wt = open_set[i].known ? open_set[i].wt : wt_of[i];
            r.last = (i == n - 1);
            awaited_results.push_back(r);
        end
        open_set.delete();
    endfunction

    // Offers one process and waits for its transfer; called at a rising edge.
    task automatic offer_process(input process_t proc);
        while (!calm && $urandom_range(99) < 9)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        arrival_time <= proc.arr;
        burst_time <= proc.bur;
        last_process <= proc.last;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        open_set.push_back(proc);
        if (proc.last || open_set.size() == MAX_PROCESSES)
            schedule_open_set();
    endtask

    // Loads a random set of n processes with the given value mix.
    task automatic load_random_set(input int n, input set_shape_t shape);
        process_t proc;
        int       k;
        for (k = 0; k < n; k++)
        begin
            case (shape)
                SHAPE_CROWD:
                begin
                    proc.arr = ARR_W'($urandom_range(31));
                    proc.bur = BUR_W'($urandom_range(15));
                end
                SHAPE_SPARSE:
                begin
                    proc.arr = ARR_W'($urandom);
                    proc.bur = BUR_W'($urandom_range(255));
                end
                SHAPE_PEAK:
                begin
                    proc.arr = '1;
                    proc.bur = '1;
                end
                default:
                begin
                    proc.arr = ARR_W'($urandom);
                    proc.bur = BUR_W'($urandom);
                end
            endcase
            // A full store ends the set whether or not the last flag is set.
            if (k == n - 1)
                proc.last = (n < MAX_PROCESSES) ? 1'b1 : 1'($urandom_range(1));
            else
                proc.last = 1'b0;
            proc.known = 1'b0;
            proc.tat = '0;
            proc.wt = '0;
            offer_process(proc);
        end
    endtask

    // Stimulus: directed table, a drain pause, then random sets.
    initial
    begin
        int i;
        rst_n = 1'b0;
        item_valid = 1'b0;
        arrival_time = '0;
        burst_time = '0;
        last_process = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_N; i++)
            offer_process(dir_rows[i]);

        // Hold off until every result of the directed sets has arrived.
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);

        // Two full sets: the longest possible schedule, then random values.
        load_random_set(MAX_PROCESSES, SHAPE_PEAK);
        load_random_set(MAX_PROCESSES, SHAPE_WIDE);

        // Small sets, mostly crowded or wide, with a stretch of steady traffic.
        while (items_sent < RANDOM_ITEMS)
        begin
            calm = (items_sent > 200 && items_sent < 260);
            load_random_set($urandom_range(1, 10), set_shape_t'($urandom_range(2)));
        end
        calm = 1'b0;

        // Drain the remaining results, then allow the block to settle.
        item_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("fcfs_schedule_times_test passed");
        else
            $display("fcfs_schedule_times_test failed");
        $finish;
    end

    // Result side stalls at random except in the steady stretch.
    always @(posedge clk)
    begin
        result_ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing expected: process_number %0d", process_number);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (process_number !== want.pnum)
                begin
                    $error("process_number: expected %0d, got %0d", want.pnum, process_number);
                    errors++;
                end
                if (turnaround_time !== want.tat)
                begin
                    $error("turnaround_time: expected %0d, got %0d", want.tat, turnaround_time);
                    errors++;
                end
                if (waiting_time !== want.wt)
                begin
                    $error("waiting_time: expected %0d, got %0d", want.wt, waiting_time);
                    errors++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result: expected %0d, got %0d", want.last, last_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("fcfs_schedule_times_test failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
design/fst_pkg.sv
design/fst_ctrl.sv
design/fst_dp.sv
design/fcfs_schedule_times.sv
design/fst_checker.sv
tb/sv/fcfs_schedule_times_test.sv
